// ===== design/saq_pkg.sv =====
// shared types and constants for the sensor alarm qualifier
// no dependencies
package saq_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LimitW   = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SOUND_TRIP   = 3'd0,
    REG_PULSE_LO     = 3'd1,
    REG_PULSE_HI     = 3'd2,
    REG_COOLDOWN     = 3'd3,
    REG_BUZZ_CRIT    = 3'd4,
    REG_BUZZ_HEART   = 3'd5,
    REG_BUZZ_NOISE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALERT_NONE  = 2'd0,
    ALERT_SOUND = 2'd1,
    ALERT_PULSE = 2'd2,
    ALERT_BOTH  = 2'd3
  } level_e;

  typedef struct packed {
    logic [7:0]        sound_trip;
    logic [LimitW-1:0] pulse_lo;
    logic [LimitW-1:0] pulse_hi;
    logic [31:0]       cooldown;
    logic [31:0]       buzz_crit;
    logic [31:0]       buzz_heart;
    logic [31:0]       buzz_noise;
  } cfg_t;

  localparam logic [7:0]        RstSoundTrip = 8'd3;
  localparam logic [LimitW-1:0] RstPulseLo   = 12'd500;
  localparam logic [LimitW-1:0] RstPulseHi   = 12'd3500;
  localparam logic [31:0]       RstCooldown  = 32'd5000;
  localparam logic [31:0]       RstBuzzCrit  = 32'd100;
  localparam logic [31:0]       RstBuzzHeart = 32'd300;
  localparam logic [31:0]       RstBuzzNoise = 32'd600;

  localparam logic [7:0] StreakMax = 8'd255;
  localparam logic [5:0] HeartCap  = 6'd50;
  localparam logic [5:0] HeartTrip = 6'd10;
  localparam logic [5:0] HeartLeak = 6'd2;

endpackage

// ===== design/sensor_alarm_qualifier.sv =====
// sensor alarm qualifier top level: input register, alarm core, result register
// depends on saq_pkg, saq_cfg_regs and saq_core
//
// one input item is one sample tick: sound bit, heart adc sample, ms timestamp.
// each item gives exactly one result item: alert level, log pulse, buzzer
// level and the echoed sound and heart values.
// the slave side registers the item; the core then updates the streak
// counter, leaky heart counter, per-level cooldown and buzzer when the item
// advances and writes the result register, whose valid bit is m_tvalid.
// throughput is one item per clock without stalls; an item is taken while a
// result waits to be taken, as the input register holds one item ahead of it.
// when the master side stalls, the result holds, one item waits in the input
// register and s_tready drops until the result is taken.
// reset clears all counters, timestamps and the buzzer, loads the register
// defaults and empties both stages. the user must write the configuration
// registers only while no item is in flight; the block does not enforce it.
module sensor_alarm_qualifier #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [saq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [saq_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // sound_bit, heart_sample, time_ms
  input  logic [((SAMPLE_BITS+33+7)/8)*8-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // alert_level, log_pulse, buzzer_on, heart_echo, sound_echo
  output logic [((SAMPLE_BITS+5+7)/8)*8-1:0]  m_tdata
);
  import saq_pkg::*;

  localparam int unsigned OutBits = SAMPLE_BITS + 5;

  cfg_t cfg;

  logic                   in_valid_q;
  logic                   in_sound_q;
  logic [SAMPLE_BITS-1:0] in_heart_q;
  logic [31:0]            in_time_q;

  logic                   out_valid_q;
  level_e                 out_level_q;
  logic                   out_log_q;
  logic                   out_buzz_q;
  logic [SAMPLE_BITS-1:0] out_heart_q;
  logic                   out_sound_q;

  logic   advance, in_take;
  level_e level;
  logic   log_now, buzz;

  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;
  assign in_take  = s_tvalid && s_tready;

  saq_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  saq_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .cfg_i    (cfg),
    .sound_i  (in_sound_q),
    .heart_i  (in_heart_q),
    .time_i   (in_time_q),
    .level_o  (level),
    .log_o    (log_now),
    .buzzer_o (buzz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sound_q <= s_tdata[0];
      in_heart_q <= s_tdata[SAMPLE_BITS:1];
      in_time_q  <= s_tdata[SAMPLE_BITS+32:SAMPLE_BITS+1];
    end
    if (advance) begin
      out_level_q <= level;
      out_log_q   <= log_now;
      out_buzz_q  <= buzz;
      out_heart_q <= in_heart_q;
      out_sound_q <= in_sound_q;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OutBits-1:0] = {out_sound_q, out_heart_q, out_buzz_q, out_log_q, out_level_q};
  end

  assign m_tvalid = out_valid_q;

endmodule

// ===== design/saq_cfg_regs.sv =====
// configuration register file of the sensor alarm qualifier
// depends on saq_pkg
module saq_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [saq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [saq_pkg::CfgDataW-1:0]  cfg_data_i,
  output saq_pkg::cfg_t                 cfg_o
);
  import saq_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sound_trip <= RstSoundTrip;
      cfg_q.pulse_lo   <= RstPulseLo;
      cfg_q.pulse_hi   <= RstPulseHi;
      cfg_q.cooldown   <= RstCooldown;
      cfg_q.buzz_crit  <= RstBuzzCrit;
      cfg_q.buzz_heart <= RstBuzzHeart;
      cfg_q.buzz_noise <= RstBuzzNoise;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SOUND_TRIP: cfg_q.sound_trip <= cfg_data_i[7:0];
        REG_PULSE_LO:   cfg_q.pulse_lo   <= cfg_data_i[LimitW-1:0];
        REG_PULSE_HI:   cfg_q.pulse_hi   <= cfg_data_i[LimitW-1:0];
        REG_COOLDOWN:   cfg_q.cooldown   <= cfg_data_i;
        REG_BUZZ_CRIT:  cfg_q.buzz_crit  <= cfg_data_i;
        REG_BUZZ_HEART: cfg_q.buzz_heart <= cfg_data_i;
        REG_BUZZ_NOISE: cfg_q.buzz_noise <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/saq_core.sv =====
// qualifier state and per-item alarm logic: debounce, leaky counter,
// level priority, log cooldown and buzzer toggle; depends on saq_pkg
module saq_core #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  saq_pkg::cfg_t          cfg_i,
  input  logic                   sound_i,
  input  logic [SAMPLE_BITS-1:0] heart_i,
  input  logic [31:0]            time_i,
  output saq_pkg::level_e        level_o,
  output logic                   log_o,
  output logic                   buzzer_o
);
  import saq_pkg::*;

  localparam int unsigned CmpW = (SAMPLE_BITS > LimitW) ? SAMPLE_BITS : LimitW;

  logic [7:0]  streak_q, streak_d;
  logic [5:0]  hcnt_q, hcnt_d;
  logic [31:0] alert_time_q [4];
  logic        buzz_q, buzz_d;
  logic [31:0] toggle_time_q;

  logic [CmpW-1:0] hv_ext, low_ext, high_ext;
  logic            out_range, sound_trip, heart_trip, toggle;
  level_e          level;
  logic [31:0]     period, alert_diff, toggle_diff;
  logic            log_now;

  always_comb begin
    hv_ext   = CmpW'(heart_i);
    low_ext  = CmpW'(cfg_i.pulse_lo);
    high_ext = CmpW'(cfg_i.pulse_hi);

    if (sound_i) begin
      streak_d = (streak_q == StreakMax) ? streak_q : streak_q + 8'd1;
    end else begin
      streak_d = '0;
    end
    sound_trip = streak_d >= cfg_i.sound_trip;

    out_range = (hv_ext < low_ext) || (hv_ext > high_ext);
    if (out_range) begin
      hcnt_d = (hcnt_q < HeartCap) ? hcnt_q + 6'd1 : hcnt_q;
    end else begin
      hcnt_d = (hcnt_q > HeartLeak) ? hcnt_q - HeartLeak : '0;
    end
    heart_trip = hcnt_d >= HeartTrip;

    if (sound_trip && heart_trip) begin
      level  = ALERT_BOTH;
      period = cfg_i.buzz_crit;
    end else if (heart_trip) begin
      level  = ALERT_PULSE;
      period = cfg_i.buzz_heart;
    end else if (sound_trip) begin
      level  = ALERT_SOUND;
      period = cfg_i.buzz_noise;
    end else begin
      level  = ALERT_NONE;
      period = '0;
    end

    alert_diff  = time_i - alert_time_q[level];
    log_now     = (level != ALERT_NONE) && (alert_diff > cfg_i.cooldown);
    toggle_diff = time_i - toggle_time_q;
    toggle      = (level != ALERT_NONE) && (toggle_diff >= period);

    if (level == ALERT_NONE) begin
      buzz_d = 1'b0;
    end else begin
      buzz_d = toggle ? ~buzz_q : buzz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streak_q      <= '0;
      hcnt_q        <= '0;
      buzz_q        <= 1'b0;
      toggle_time_q <= '0;
      for (int i = 0; i < 4; i++) begin
        alert_time_q[i] <= '0;
      end
    end else if (en_i) begin
      streak_q <= streak_d;
      hcnt_q   <= hcnt_d;
      buzz_q   <= buzz_d;
      if (toggle) begin
        toggle_time_q <= time_i;
      end
      if (log_now) begin
        alert_time_q[level] <= time_i;
      end
    end
  end

  assign level_o  = level;
  assign log_o    = log_now;
  assign buzzer_o = buzz_d;

endmodule

// ===== test/sensor_alarm_qualifier_tb.sv =====
// testbench for sensor_alarm_qualifier: directed and random sample ticks
// checked against a cycle-free predictor of the qualifier
// depends on saq_pkg and sensor_alarm_qualifier
module sensor_alarm_qualifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleW = 12;
  localparam int unsigned InW     = ((SampleW + 33 + 7) / 8) * 8;
  localparam int unsigned OutW    = ((SampleW + 5 + 7) / 8) * 8;

  localparam logic [7:0] StreakTop = 8'd255;
  localparam logic [5:0] OutCap    = 6'd50;
  localparam logic [5:0] OutTrip   = 6'd10;
  localparam logic [5:0] OutLeak   = 6'd2;

  localparam logic [saq_pkg::CfgIdxW-1:0] IdxUnused = 3'd7;

  localparam saq_pkg::cfg_t DefaultCfg = '{
    sound_trip: 8'd3,   pulse_lo: 12'd500, pulse_hi: 12'd3500,
    cooldown:   32'd5000, buzz_crit: 32'd100, buzz_heart: 32'd300,
    buzz_noise: 32'd600
  };

  typedef struct packed {
    logic [31:0]        ms;
    logic [SampleW-1:0] heart;
    logic               snd;
  } sample_t;

  typedef struct packed {
    logic               snd;
    logic [SampleW-1:0] heart;
    logic               buzz;
    logic               log_p;
    saq_pkg::level_e    level;
  } alarm_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [saq_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [saq_pkg::CfgDataW-1:0]  cfg_data_i;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [InW-1:0]                s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [OutW-1:0]               m_tdata;

  sensor_alarm_qualifier #(.SAMPLE_BITS(SampleW)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // predictor state
  saq_pkg::cfg_t cfg_now;
  logic [7:0]    streak;
  logic [5:0]    heart_cnt;
  logic [31:0]   last_log_ms [4];
  logic          buzz_lvl;
  logic [31:0]   last_toggle_ms;

  alarm_t expected_alarms [$];
  int     fail_count;
  int     src_idle_pct;
  int     sink_idle_pct;

  // random sequence state
  logic [31:0] now_ms;
  logic        snd_run;
  int          snd_left;
  logic        heart_run_out;
  int          heart_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic alarm_t qualify_tick(input sample_t t);
    alarm_t      r;
    logic        snd_hit;
    logic        heart_hit;
    logic [31:0] period;
    logic [31:0] since;
    if (t.snd) begin
      if (streak != StreakTop) streak = streak + 8'd1;
    end else begin
      streak = 8'd0;
    end
    snd_hit = (streak >= cfg_now.sound_trip);
    if (t.heart < cfg_now.pulse_lo || t.heart > cfg_now.pulse_hi) begin
      if (heart_cnt < OutCap) heart_cnt = heart_cnt + 6'd1;
    end else begin
      heart_cnt = (heart_cnt > OutLeak) ? heart_cnt - OutLeak : 6'd0;
    end
    heart_hit = (heart_cnt >= OutTrip);
    if (snd_hit && heart_hit) begin
      r.level = saq_pkg::ALERT_BOTH;
      period  = cfg_now.buzz_crit;
    end else if (heart_hit) begin
      r.level = saq_pkg::ALERT_PULSE;
      period  = cfg_now.buzz_heart;
    end else if (snd_hit) begin
      r.level = saq_pkg::ALERT_SOUND;
      period  = cfg_now.buzz_noise;
    end else begin
      r.level = saq_pkg::ALERT_NONE;
      period  = 32'd0;
    end
    r.log_p = 1'b0;
    if (r.level != saq_pkg::ALERT_NONE) begin
      since = t.ms - last_log_ms[r.level];
      if (since > cfg_now.cooldown) begin
        last_log_ms[r.level] = t.ms;
        r.log_p = 1'b1;
      end
      since = t.ms - last_toggle_ms;
      if (since >= period) begin
        buzz_lvl       = ~buzz_lvl;
        last_toggle_ms = t.ms;
      end
    end else begin
      buzz_lvl = 1'b0;
    end
    r.buzz  = buzz_lvl;
    r.heart = t.heart;
    r.snd   = t.snd;
    return r;
  endfunction

  // result checker
  initial begin
    alarm_t got;
    alarm_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_tvalid && m_tready) begin
        got = alarm_t'(m_tdata[16:0]);
        if (expected_alarms.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result item: lvl %0d log %0b buzz %0b heart %0d snd %0b",
                     got.level, got.log_p, got.buzz, got.heart, got.snd);
          fail_count++;
        end else begin
          want = expected_alarms.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: expected lvl %0d log %0b buzz %0b heart %0d snd %0b",
                       want.level, want.log_p, want.buzz, want.heart, want.snd);
              $display("          got      lvl %0d log %0b buzz %0b heart %0d snd %0b",
                       got.level, got.log_p, got.buzz, got.heart, got.snd);
            end
            fail_count++;
          end
        end
      end
    end
  end

  // result receiver with random stalls
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  task automatic send_item(input sample_t it);
    logic taken;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InW'({it.ms, it.heart, it.snd});
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_tready;
      @(posedge clk_i);
    end
    expected_alarms.push_back(qualify_tick(it));
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (expected_alarms.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [saq_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic apply_settings(input saq_pkg::cfg_t c, input bit poke_unused);
    if (poke_unused) write_reg(IdxUnused, $urandom);
    write_reg(saq_pkg::REG_SOUND_TRIP, ($urandom & 32'hFFFF_FF00) | 32'(c.sound_trip));
    write_reg(saq_pkg::REG_PULSE_LO,   ($urandom & 32'hFFFF_F000) | 32'(c.pulse_lo));
    write_reg(saq_pkg::REG_PULSE_HI,   ($urandom & 32'hFFFF_F000) | 32'(c.pulse_hi));
    write_reg(saq_pkg::REG_COOLDOWN,   c.cooldown);
    write_reg(saq_pkg::REG_BUZZ_CRIT,  c.buzz_crit);
    write_reg(saq_pkg::REG_BUZZ_HEART, c.buzz_heart);
    write_reg(saq_pkg::REG_BUZZ_NOISE, c.buzz_noise);
    cfg_we_i <= 1'b0;
    cfg_now = c;
    @(posedge clk_i);
  endtask

  function automatic sample_t mk(input logic snd, input int heart, input logic [31:0] ms);
    sample_t s;
    s.snd   = snd;
    s.heart = SampleW'(heart);
    s.ms    = ms;
    return s;
  endfunction

  function automatic logic [SampleW-1:0] pick_heart(input logic want_out);
    int lo;
    int hi;
    lo = int'(cfg_now.pulse_lo);
    hi = int'(cfg_now.pulse_hi);
    if ($urandom_range(19, 0) == 0) return SampleW'($urandom_range(4095, 0));
    if (want_out) begin
      if (lo != 0 && (hi == 4095 || $urandom_range(1, 0) == 1))
        return SampleW'($urandom_range(lo - 1, 0));
      if (hi != 4095) return SampleW'($urandom_range(4095, hi + 1));
    end else if (lo <= hi) begin
      return SampleW'($urandom_range(hi, lo));
    end
    return SampleW'($urandom_range(4095, 0));
  endfunction

  task automatic next_sample(output sample_t it);
    int pick;
    if (snd_left == 0) begin
      snd_run  = ($urandom_range(3, 0) == 0) ? snd_run : ~snd_run;
      snd_left = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 20) : $urandom_range(12, 1);
    end
    if (heart_left == 0) begin
      heart_run_out = ~heart_run_out;
      heart_left    = $urandom_range(25, 1);
    end
    snd_left--;
    heart_left--;
    pick = $urandom_range(99, 0);
    if (pick < 85) now_ms = now_ms + $urandom_range(40, 0);
    else if (pick < 95) now_ms = now_ms + $urandom_range(3000, 41);
    else now_ms = $urandom;
    // glitches only near the end of a run so long runs reach the streak limit
    it.snd   = (snd_left < 20 && $urandom_range(29, 0) == 0) ? ~snd_run : snd_run;
    it.heart = pick_heart(heart_run_out);
    it.ms    = now_ms;
  endtask

  task automatic test_reset_defaults();
    send_item(mk(1'b1, 0, 32'd0));
    send_item(mk(1'b1, 4095, 32'd1));
    send_item(mk(1'b1, 499, 32'd2));
    send_item(mk(1'b1, 3501, 32'hFFFF_FFFF));
    send_item(mk(1'b0, 500, 32'd100));
    send_item(mk(1'b0, 3500, 32'd200));
    send_item(mk(1'b1, 2048, 32'd300));
    wait_results_done();
  endtask

  // heart trips alone, then with sound for critical, then heart alone again
  task automatic test_level_priority();
    for (int i = 0; i < 14; i++)
      send_item(mk(i >= 10 && i < 13, (i % 2 == 0) ? 0 : 4095, 32'(10000 + 2000 * i)));
    wait_results_done();
  endtask

  // zero trip count, zero cooldown and zero periods, plus an unknown index
  task automatic test_zero_settings();
    saq_pkg::cfg_t c;
    c = DefaultCfg;
    c.sound_trip = 8'd0;
    c.cooldown   = 32'd0;
    c.buzz_crit  = 32'd0;
    c.buzz_heart = 32'd0;
    c.buzz_noise = 32'd0;
    apply_settings(c, 1'b1);
    send_item(mk(1'b0, 2000, 32'd50000));
    send_item(mk(1'b0, 2000, 32'd50000));
    send_item(mk(1'b1, 2000, 32'd50001));
    wait_results_done();
  endtask

  task automatic test_crossed_limits();
    saq_pkg::cfg_t c;
    c = DefaultCfg;
    c.sound_trip = 8'd1;
    c.pulse_lo   = 12'd3000;
    c.pulse_hi   = 12'd1000;
    apply_settings(c, 1'b0);
    send_item(mk(1'b0, 2000, 32'd60000));
    send_item(mk(1'b1, 2000, 32'd60010));
    wait_results_done();
  endtask

  task automatic test_random_phase(input saq_pkg::cfg_t c, input int n_items);
    sample_t it;
    apply_settings(c, 1'b0);
    now_ms     = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FF00 + $urandom_range(255, 0) : $urandom;
    snd_left   = 0;
    heart_left = 0;
    if (c.sound_trip > 8'd200) begin
      snd_run  = 1'b1;
      snd_left = 280;
    end
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_results_done();
      next_sample(it);
      send_item(it);
    end
    wait_results_done();
  endtask

  function automatic saq_pkg::cfg_t random_cfg(input bit wide);
    saq_pkg::cfg_t c;
    if (wide) begin
      c.sound_trip = 8'($urandom);
      c.pulse_lo   = 12'($urandom);
      c.pulse_hi   = 12'($urandom);
      c.cooldown   = $urandom;
      c.buzz_crit  = $urandom;
      c.buzz_heart = $urandom;
      c.buzz_noise = $urandom;
    end else begin
      c.sound_trip = 8'($urandom_range(12, 1));
      c.pulse_lo   = 12'($urandom_range(1500, 0));
      c.pulse_hi   = 12'($urandom_range(4095, 2500));
      c.cooldown   = $urandom_range(400, 0);
      c.buzz_crit  = $urandom_range(150, 0);
      c.buzz_heart = $urandom_range(150, 0);
      c.buzz_noise = $urandom_range(150, 0);
    end
    return c;
  endfunction

  task automatic test_random_sweep();
    saq_pkg::cfg_t c;
    set_idling(35, 51);
    test_random_phase(DefaultCfg, 140);
    // streak saturation with the largest trip count, heart never out of range
    c = '{sound_trip: 8'd255, pulse_lo: 12'd0, pulse_hi: 12'd4095,
          cooldown: 32'd0, buzz_crit: 32'hFFFF_FFFF, buzz_heart: 32'hFFFF_FFFF,
          buzz_noise: 32'hFFFF_FFFF};
    test_random_phase(c, 300);
    c = '{sound_trip: 8'd1, pulse_lo: 12'd4095, pulse_hi: 12'd0,
          cooldown: 32'hFFFF_FFFF, buzz_crit: 32'd0, buzz_heart: 32'd0,
          buzz_noise: 32'd0};
    test_random_phase(c, 140);
    set_idling(51, 35);
    repeat (3) test_random_phase(random_cfg(1'b0), 140);
    set_idling(0, 0);
    test_random_phase(random_cfg(1'b0), 140);
    test_random_phase(random_cfg(1'b1), 140);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    fail_count     = 0;
    cfg_now        = DefaultCfg;
    streak         = '0;
    heart_cnt      = '0;
    last_log_ms    = '{default: '0};
    buzz_lvl       = 1'b0;
    last_toggle_ms = '0;
    snd_run        = 1'b0;
    heart_run_out  = 1'b0;
    snd_left       = 0;
    heart_left     = 0;
    now_ms         = '0;
    set_idling(35, 51);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_level_priority();
    test_zero_settings();
    test_crossed_limits();
    test_random_sweep();

    wait_results_done();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_alarms.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
